// ----- sv/spp_pkg.sv -----
package spp_pkg;

    localparam int unsigned SPP_FRAME_SAMPLES = 256;

    localparam int SAMPLE_W = 12;
    localparam int INDEX_W  = 8;
    localparam int COL_W    = 10;
    localparam int STEP_W   = 4;
    localparam int ROW_W    = 8;
    localparam int COLOR_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ROW_W-1:0] ROW_TOP    = 8'd33;
    localparam logic [ROW_W-1:0] ROW_BOTTOM = 8'd112;
    localparam logic [ROW_W-1:0] ROW_BASE   = 8'd113;

    // Division by 50 over 12-bit samples as a multiply by ceil(2^16 / 50).
    localparam logic [10:0] DIV50_RECIP = 11'd1311;
    localparam int          DIV50_SHIFT = 16;

    localparam logic [INDEX_W-1:0]  RST_WINDOW_LOW  = 8'd20;
    localparam logic [INDEX_W-1:0]  RST_WINDOW_HIGH = 8'd102;
    localparam logic [COL_W-1:0]    RST_X_START     = 10'd20;
    localparam logic [STEP_W-1:0]   RST_X_STEP      = 4'd3;
    localparam logic [COLOR_W-1:0]  RST_TRACE_COLOR = 16'h7fe0;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_THRESH = 12'd4000;
    localparam logic [SAMPLE_W-1:0] RST_LOW_THRESH  = 12'd100;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 12'd4095;

    typedef enum logic [1:0] {
        KIND_SLOPE   = 2'd0,
        KIND_RISE    = 2'd1,
        KIND_FALL    = 2'd2,
        KIND_PEAKS   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW  = 3'd0,
        CFG_WINDOW_HIGH = 3'd1,
        CFG_X_START     = 3'd2,
        CFG_X_STEP      = 3'd3,
        CFG_TRACE_COLOR = 3'd4,
        CFG_HIGH_THRESH = 3'd5,
        CFG_LOW_THRESH  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic                has_line;
        t_kind               kind;
        logic [COL_W-1:0]    x_from;
        logic [ROW_W-1:0]    y_from;
        logic [COL_W-1:0]    x_to;
        logic [ROW_W-1:0]    y_to;
        logic [COLOR_W-1:0]  color;
        logic                has_peaks;
        logic [SAMPLE_W-1:0] peak_max;
        logic [SAMPLE_W-1:0] peak_min;
    } t_entry;

endpackage

// ----- sv/spp_in_if.sv -----
interface spp_in_if import spp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

// ----- sv/spp_out_if.sv -----
interface spp_out_if import spp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [COL_W-1:0]    x_from;
    logic [ROW_W-1:0]    y_from;
    logic [COL_W-1:0]    x_to;
    logic [ROW_W-1:0]    y_to;
    logic [COLOR_W-1:0]  cmd_color;
    logic [SAMPLE_W-1:0] peak_max;
    logic [SAMPLE_W-1:0] peak_min;
    logic                last;

    modport source (output valid, output kind, output x_from, output y_from, output x_to,
                    output y_to, output cmd_color, output peak_max, output peak_min,
                    output last, input ready);
    modport sink   (input valid, input kind, input x_from, input y_from, input x_to,
                    input y_to, input cmd_color, input peak_max, input peak_min,
                    input last, output ready);
endinterface

// ----- sv/scope_trace_segment_plotter_core.sv -----
// Results are registered in the result queue; one sample per cycle while it has room.
// A frame-end sample that also draws a line yields two results from one entry, which keeps
// its slot until both are taken and so can hold off the input.
// Each sample is handled by one pass through the row multiplier and compares.
// A two-entry result queue absorbs short output stalls; input waits while both are full.
// Reset (synchronous, active low) restores the register defaults and clears the trace state.
module scope_trace_segment_plotter_core import spp_pkg::*; #(
    parameter int unsigned FRAME_SAMPLES = SPP_FRAME_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    spp_in_if.sink                i_smp,
    spp_out_if.source             o_cmd
);

    logic [INDEX_W-1:0]  r_window_low, r_window_high;
    logic [COL_W-1:0]    r_x_start;
    logic [STEP_W-1:0]   r_x_step;
    logic [COLOR_W-1:0]  r_trace_color;
    logic [SAMPLE_W-1:0] r_high_thresh, r_low_thresh;

    logic [SAMPLE_W-1:0] r_prev;
    logic [ROW_W-1:0]    r_prev_row;
    logic [INDEX_W-1:0]  r_index;
    logic [COL_W-1:0]    r_col;
    logic [SAMPLE_W-1:0] r_max, r_min;
    logic                r_seeded;

    t_entry              r_q [2];
    logic                r_wr, r_rd, r_phase;
    logic [1:0]          r_count;

    logic                accept, push, pop, out_fire, show_line;
    logic [INDEX_W-1:0]  pair_idx;
    logic                windowed, rising, falling;
    logic [22:0]         prod;
    logic [ROW_W-1:0]    y_new;
    logic [COL_W-1:0]    new_col;
    logic [SAMPLE_W-1:0] eff_max, eff_min, n_max, n_min;
    t_entry              n_entry, head;

    assign accept = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_count != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low  <= RST_WINDOW_LOW;
            r_window_high <= RST_WINDOW_HIGH;
            r_x_start     <= RST_X_START;
            r_x_step      <= RST_X_STEP;
            r_trace_color <= RST_TRACE_COLOR;
            r_high_thresh <= RST_HIGH_THRESH;
            r_low_thresh  <= RST_LOW_THRESH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WINDOW_LOW:  r_window_low  <= i_cfg_data[INDEX_W-1:0];
                CFG_WINDOW_HIGH: r_window_high <= i_cfg_data[INDEX_W-1:0];
                CFG_X_START:     r_x_start     <= i_cfg_data[COL_W-1:0];
                CFG_X_STEP:      r_x_step      <= i_cfg_data[STEP_W-1:0];
                CFG_TRACE_COLOR: r_trace_color <= i_cfg_data[COLOR_W-1:0];
                CFG_HIGH_THRESH: r_high_thresh <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOW_THRESH:  r_low_thresh  <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pair_idx = r_index - 8'd1;
        windowed = (r_index != '0) && (pair_idx >= r_window_low)
                   && (pair_idx <= r_window_high)
                   && (32'(r_index) < FRAME_SAMPLES);
        prod     = 23'(i_smp.sample) * 23'(DIV50_RECIP);
        y_new    = ROW_BASE - {1'b0, prod[DIV50_SHIFT+6:DIV50_SHIFT]};
        new_col  = r_col + COL_W'(r_x_step);
        rising   = (i_smp.sample > r_high_thresh) && (r_prev < r_low_thresh);
        falling  = (i_smp.sample < r_low_thresh) && (r_prev > r_high_thresh);
        eff_max  = r_seeded ? r_max : r_prev;
        eff_min  = r_seeded ? r_min : r_prev;
        n_max    = eff_max;
        n_min    = eff_min;
        if (!rising && !falling) begin
            if (r_prev >= eff_max) n_max = r_prev;
            if (r_prev < eff_min)  n_min = r_prev;
        end
        if (!windowed) begin
            n_max = r_max;
            n_min = r_min;
        end

        n_entry.has_line  = windowed;
        n_entry.x_to      = new_col;
        n_entry.color     = r_trace_color;
        n_entry.has_peaks = i_smp.frame_end;
        n_entry.peak_max  = n_max;
        n_entry.peak_min  = n_min;
        if (rising) begin
            n_entry.kind   = KIND_RISE;
            n_entry.x_from = new_col;
            n_entry.y_from = y_new;
            n_entry.y_to   = ROW_BOTTOM;
        end else if (falling) begin
            n_entry.kind   = KIND_FALL;
            n_entry.x_from = new_col;
            n_entry.y_from = y_new;
            n_entry.y_to   = ROW_TOP;
        end else begin
            n_entry.kind   = KIND_SLOPE;
            n_entry.x_from = r_col;
            n_entry.y_from = r_prev_row;
            n_entry.y_to   = y_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_prev_row <= ROW_BASE;
            r_index    <= '0;
            r_col      <= RST_X_START;
            r_max      <= '0;
            r_min      <= SAMPLE_MAX;
            r_seeded   <= 1'b0;
        end else if (accept) begin
            r_prev     <= i_smp.sample;
            r_prev_row <= y_new;
            if (r_index == '0) begin
                r_col <= r_x_start;
            end else if (windowed) begin
                r_col <= new_col;
            end
            if (i_smp.frame_end) begin
                r_max    <= '0;
                r_min    <= SAMPLE_MAX;
                r_seeded <= 1'b0;
                r_index  <= '0;
            end else begin
                r_max   <= n_max;
                r_min   <= n_min;
                r_index <= r_index + 8'd1;
                if (windowed) r_seeded <= 1'b1;
            end
        end
    end

    assign push      = accept && (windowed || i_smp.frame_end);
    assign head      = r_q[r_rd];
    assign show_line = head.has_line && !r_phase;
    assign out_fire  = o_cmd.valid && o_cmd.ready;
    assign pop       = out_fire && !(show_line && head.has_peaks);

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_phase <= 1'b0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            if (out_fire) r_phase <= show_line && head.has_peaks;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_comb begin
        o_cmd.valid      = (r_count != '0);
        o_cmd.kind       = show_line ? head.kind : KIND_PEAKS;
        o_cmd.x_from     = show_line ? head.x_from : '0;
        o_cmd.y_from     = show_line ? head.y_from : '0;
        o_cmd.x_to       = show_line ? head.x_to : '0;
        o_cmd.y_to       = show_line ? head.y_to : '0;
        o_cmd.cmd_color  = show_line ? head.color : '0;
        o_cmd.peak_max   = show_line ? '0 : head.peak_max;
        o_cmd.peak_min   = show_line ? '0 : head.peak_min;
        o_cmd.last       = !show_line;
    end

    a_phase_only_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (head.has_line && head.has_peaks && r_count != '0))
        else $error("Second result pending on an entry without both results.");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_smp.frame_end) |=> (r_index == '0 && !r_seeded))
        else $error("Frame end did not clear the index and peak seed.");

    a_last_is_peaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.last == (o_cmd.kind == KIND_PEAKS)))
        else $error("Last flag disagrees with the result kind.");

    a_peaks_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |-> (r_max >= r_min))
        else $error("Running maximum fell below running minimum.");

endmodule

// ----- tb/sv/scope_trace_segment_plotter_core_tb.sv -----
module scope_trace_segment_plotter_core_tb;
    import spp_pkg::*;

    typedef struct packed {
        t_kind               kind;
        logic [COL_W-1:0]    x_from;
        logic [ROW_W-1:0]    y_from;
        logic [COL_W-1:0]    x_to;
        logic [ROW_W-1:0]    y_to;
        logic [COLOR_W-1:0]  color;
        logic [SAMPLE_W-1:0] pk_max;
        logic [SAMPLE_W-1:0] pk_min;
        logic                last;
    } t_plot_cmd;

    localparam int STALL_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    spp_in_if  smp ();
    spp_out_if cmd ();

    scope_trace_segment_plotter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp),
        .o_cmd      (cmd)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and trace state of the prediction.
    logic [INDEX_W-1:0]  cfg_win_lo  = RST_WINDOW_LOW;
    logic [INDEX_W-1:0]  cfg_win_hi  = RST_WINDOW_HIGH;
    logic [COL_W-1:0]    cfg_x_start = RST_X_START;
    logic [STEP_W-1:0]   cfg_x_step  = RST_X_STEP;
    logic [COLOR_W-1:0]  cfg_color   = RST_TRACE_COLOR;
    logic [SAMPLE_W-1:0] cfg_hi      = RST_HIGH_THRESH;
    logic [SAMPLE_W-1:0] cfg_lo      = RST_LOW_THRESH;

    logic [SAMPLE_W-1:0] trc_prev   = '0;
    logic [INDEX_W-1:0]  trc_idx    = '0;
    logic [COL_W-1:0]    trc_col    = RST_X_START;
    logic [SAMPLE_W-1:0] trc_max    = '0;
    logic [SAMPLE_W-1:0] trc_min    = SAMPLE_MAX;
    logic                trc_seeded = 1'b0;

    t_plot_cmd pending_cmds[$];
    t_plot_cmd want_cmd;
    int        err_cnt = 0;
    int        samples_sent = 0;
    int        idle_cycles = 0;
    int        ready_hold = 0;
    bit        steady = 1'b0;

    function automatic logic [ROW_W-1:0] screen_row(input logic [SAMPLE_W-1:0] s);
        return ROW_BASE - ROW_W'(s / 50);
    endfunction

    task automatic plot_sample(input logic [SAMPLE_W-1:0] s, input logic fe);
        logic [INDEX_W-1:0] pair_idx;
        logic [COL_W-1:0]   old_col;
        logic [COL_W-1:0]   new_col;
        t_plot_cmd          c;
        if (trc_idx == '0) begin
            trc_col = cfg_x_start;
        end else begin
            pair_idx = trc_idx - 1'b1;
            if (pair_idx >= cfg_win_lo && pair_idx <= cfg_win_hi &&
                int'(trc_idx) < SPP_FRAME_SAMPLES) begin
                old_col = trc_col;
                new_col = trc_col + COL_W'(cfg_x_step);
                if (!trc_seeded) begin
                    trc_max    = trc_prev;
                    trc_min    = trc_prev;
                    trc_seeded = 1'b1;
                end
                trc_col = new_col;
                c = '0;
                c.color = cfg_color;
                c.x_to  = new_col;
                c.y_from = screen_row(s);
                if (s > cfg_hi && trc_prev < cfg_lo) begin
                    c.kind   = KIND_RISE;
                    c.x_from = new_col;
                    c.y_to   = ROW_BOTTOM;
                end else if (s < cfg_lo && trc_prev > cfg_hi) begin
                    c.kind   = KIND_FALL;
                    c.x_from = new_col;
                    c.y_to   = ROW_TOP;
                end else begin
                    if (trc_prev >= trc_max) trc_max = trc_prev;
                    if (trc_prev < trc_min) trc_min = trc_prev;
                    c.kind   = KIND_SLOPE;
                    c.x_from = old_col;
                    c.y_from = screen_row(trc_prev);
                    c.y_to   = screen_row(s);
                end
                pending_cmds.push_back(c);
            end
        end
        trc_prev = s;
        if (fe) begin
            c = '0;
            c.kind   = KIND_PEAKS;
            c.pk_max = trc_max;
            c.pk_min = trc_min;
            c.last   = 1'b1;
            pending_cmds.push_back(c);
            trc_max    = '0;
            trc_min    = SAMPLE_MAX;
            trc_seeded = 1'b0;
            trc_idx    = '0;
        end else begin
            trc_idx = trc_idx + 1'b1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fe);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid     <= 1'b1;
        smp.sample    <= s;
        smp.frame_end <= fe;
        do @(posedge i_clk); while (!smp.ready);
        plot_sample(s, fe);
        samples_sent++;
    endtask

    task automatic wait_drain();
        smp.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (r)
            CFG_WINDOW_LOW:  cfg_win_lo  = v[INDEX_W-1:0];
            CFG_WINDOW_HIGH: cfg_win_hi  = v[INDEX_W-1:0];
            CFG_X_START:     cfg_x_start = v[COL_W-1:0];
            CFG_X_STEP:      cfg_x_step  = v[STEP_W-1:0];
            CFG_TRACE_COLOR: cfg_color   = v[COLOR_W-1:0];
            CFG_HIGH_THRESH: cfg_hi      = v[SAMPLE_W-1:0];
            CFG_LOW_THRESH:  cfg_lo      = v[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int wl, input int wh, input int xs, input int st,
                                  input int col, input int ht, input int lt);
        write_reg(CFG_WINDOW_LOW, CFG_DATA_W'(wl));
        write_reg(CFG_WINDOW_HIGH, CFG_DATA_W'(wh));
        write_reg(CFG_X_START, CFG_DATA_W'(xs));
        write_reg(CFG_X_STEP, CFG_DATA_W'(st));
        write_reg(CFG_TRACE_COLOR, CFG_DATA_W'(col));
        write_reg(CFG_HIGH_THRESH, CFG_DATA_W'(ht));
        write_reg(CFG_LOW_THRESH, CFG_DATA_W'(lt));
        i_cfg_we <= 1'b0;
    endtask

    // Samples are steered towards the thresholds so that jumps and their edges occur often.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 20) v = $urandom_range(0, 4095);
        else if (r < 45) v = $urandom_range(int'(cfg_hi), 4095);
        else if (r < 70) v = $urandom_range(0, int'(cfg_lo));
        else if (r < 80) v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        else begin
            v = (($urandom_range(0, 1) != 0) ? int'(cfg_hi) : int'(cfg_lo))
                + $urandom_range(0, 4) - 2;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
        end
        return SAMPLE_W'(v);
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    endtask

    task automatic test_reset_defaults();
        send_frame(120);
        wait_drain();
    endtask

    task automatic test_directed();
        logic [SAMPLE_W-1:0] seq[12] = '{0, 4095, 0, 2000, 4095, 4000, 99, 4001, 100,
                                          4001, 0, 49};
        apply_settings(0, 255, 1020, 15, 16'hffff, 4000, 100);
        foreach (seq[i]) send_sample(seq[i], i == 11);
        send_sample(12'd2048, 1'b1);
        send_sample(12'd50, 1'b0);
        send_sample(12'd4049, 1'b1);
        wait_drain();
    endtask

    task automatic test_long_frame();
        apply_settings(240, 255, 500, 1, 16'h0001, 4000, 100);
        send_frame(520);
        wait_drain();
    endtask

    task automatic test_reversed_window();
        apply_settings(200, 10, 0, 7, 16'h8000, 2000, 2000);
        send_frame(30);
        wait_drain();
    endtask

    task automatic test_zero_step();
        apply_settings(0, 255, 1023, 0, 16'h5555, 3000, 1000);
        send_frame(20);
        wait_drain();
    endtask

    task automatic test_random();
        int wl, wh, ht, lt, len, goal;
        for (int phase = 0; phase < 10; phase++) begin
            wl = $urandom_range(0, 30);
            wh = wl + $urandom_range(0, 50);
            if ($urandom_range(0, 99) < 15) begin
                wl = $urandom_range(0, 255);
                wh = $urandom_range(0, 255);
            end
            ht = ($urandom_range(0, 9) < 7) ? $urandom_range(3500, 4095) : $urandom_range(0, 4095);
            lt = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 600) : $urandom_range(0, 4095);
            if (phase == 0) begin
                ht = 4095;
                lt = 0;
            end else if (phase == 1) begin
                wl = 0;
                wh = 255;
                ht = 0;
                lt = 4095;
            end
            apply_settings(wl, wh, (phase == 1) ? 1023 : $urandom_range(0, 1023),
                           (phase == 1) ? 15 : $urandom_range(0, 15), $urandom(), ht, lt);
            steady = (phase == 3);
            goal = samples_sent + 90;
            while (samples_sent < goal) begin
                len = $urandom_range(0, 99);
                if (len < 2) len = $urandom_range(257, 300);
                else if (len < 7) len = 1;
                else len = $urandom_range(2, 60);
                send_frame(len);
                // Hold the sender after each early frame until all output is drained.
                if (phase == 5 && samples_sent < goal - 30) begin
                    wait_drain();
                end
            end
            steady = 1'b0;
            wait_drain();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && cmd.valid && cmd.ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command, expected none, actual kind %0d",
                         $time, cmd.kind);
                err_cnt++;
            end else begin
                want_cmd = pending_cmds.pop_front();
                check_field("kind", want_cmd.kind, cmd.kind);
                check_field("x_from", want_cmd.x_from, cmd.x_from);
                check_field("y_from", want_cmd.y_from, cmd.y_from);
                check_field("x_to", want_cmd.x_to, cmd.x_to);
                check_field("y_to", want_cmd.y_to, cmd.y_to);
                check_field("cmd_color", want_cmd.color, cmd.cmd_color);
                check_field("peak_max", want_cmd.pk_max, cmd.peak_max);
                check_field("peak_min", want_cmd.pk_min, cmd.peak_min);
                check_field("last", want_cmd.last, cmd.last);
            end
        end
    end

    initial begin
        cmd.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady) begin
                cmd.ready <= 1'b1;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                ready_hold = $urandom_range(0, 99);
                if (ready_hold < 60) begin
                    cmd.ready <= 1'b1;
                    ready_hold = $urandom_range(0, 7);
                end else if (ready_hold < 93) begin
                    cmd.ready <= 1'b0;
                    ready_hold = $urandom_range(0, 2);
                end else begin
                    cmd.ready <= 1'b0;
                    ready_hold = $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (cmd.valid && cmd.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("scope_trace_segment_plotter_core_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW_LOW;
        i_cfg_data    <= '0;
        smp.valid     <= 1'b0;
        smp.sample    <= '0;
        smp.frame_end <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_long_frame();
        test_reversed_window();
        test_zero_step();
        test_random();
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pending_cmds.size() == 0) begin
            $display("scope_trace_segment_plotter_core_tb: clean");
        end else begin
            $display("scope_trace_segment_plotter_core_tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/spp_pkg.sv
sv/spp_in_if.sv
sv/spp_out_if.sv
sv/scope_trace_segment_plotter_core.sv
tb/sv/scope_trace_segment_plotter_core_tb.sv
